FILE: rtl/core/tre_pkg.sv
// ----------------------------------------------------------------------------
// tre_pkg
// Shared types and constants of the TGA run-length line encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tre_pkg;

    // Width of run lengths and chunk sizes carried between the parts.
    localparam int LEN_W   = 8;
    localparam int PIX_W   = 32;
    localparam int LANES   = 4;
    localparam int BPP_W   = 3;

    // Base of a repetition chunk header.
    localparam logic [7:0] REP_BASE = 8'h7f;

    // Configuration register index and its reset value.
    localparam logic       REG_BPP   = 1'b0;
    localparam logic [2:0] BPP_RESET = 3'd4;

    // What happens to the run that an input item closes.
    typedef enum logic [1:0] {
        X_NONE   = 2'd0,
        X_APPEND = 2'd1,
        X_REP    = 2'd2
    } t_xkind;

    // One command from the front part to the back part.
    typedef struct packed {
        t_xkind             x_kind;
        logic [LEN_W-1:0]   x_len;
        logic [PIX_W-1:0]   x_pixel;
        logic               end_flag;
        logic [LEN_W-1:0]   end_len;
        logic [PIX_W-1:0]   end_pixel;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/tre_in_if.sv
// ----------------------------------------------------------------------------
// tre_in_if
// Pixel input channel: one pixel and its line-end flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tre_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_value;
    logic        line_end;

    modport source (output valid, output pixel_value, output line_end, input ready);
    modport sink   (input valid, input pixel_value, input line_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tre_out_if.sv
// ----------------------------------------------------------------------------
// tre_out_if
// Encoded output channel: an optional header and up to four pixels per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tre_out_if;
    logic        valid;
    logic        ready;
    logic        header_valid;
    logic [7:0]  header_byte;
    logic [2:0]  pixel_count;
    logic [31:0] pixel_a;
    logic [31:0] pixel_b;
    logic [31:0] pixel_c;
    logic [31:0] pixel_d;
    logic        line_done;
    logic        step_last;

    modport source (
        output valid, output header_valid, output header_byte, output pixel_count,
        output pixel_a, output pixel_b, output pixel_c, output pixel_d,
        output line_done, output step_last, input ready
    );
    modport sink (
        input valid, input header_valid, input header_byte, input pixel_count,
        input pixel_a, input pixel_b, input pixel_c, input pixel_d,
        input line_done, input step_last, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/tre_front.sv
// ----------------------------------------------------------------------------
// tre_front
// Run detector: masks each pixel, tracks the open run and issues one
// command per pixel that closes a run or ends a line.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_front #(
    parameter int CHUNK_MAX = 128
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [2:0]            i_bpp,
    tre_in_if.sink                     i_pix,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output tre_pkg::t_cmd              o_cmd
);
    import tre_pkg::*;

    localparam int CW = $clog2(CHUNK_MAX + 1);

    logic [PIX_W-1:0] r_run_pixel, n_run_pixel;
    logic [CW-1:0]    r_run_len, n_run_len;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] mask;
    logic             extend;
    logic             accept;
    logic [CW-1:0]    new_len;
    logic [PIX_W-1:0] new_pix;

    // Byte mask of the compared pixel width.
    always_comb begin
        case (i_bpp)
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
    end

    assign px          = i_pix.pixel_value & mask;
    assign i_pix.ready = !i_q_full;
    assign accept      = i_pix.valid && !i_q_full;
    assign extend      = (r_run_len != '0) && (px == r_run_pixel) &&
                         (r_run_len < CW'(CHUNK_MAX));

    // Classify the closed run and build the command.
    always_comb begin
        o_cmd.x_kind    = X_NONE;
        o_cmd.x_len     = LEN_W'(r_run_len);
        o_cmd.x_pixel   = r_run_pixel;
        if (extend) begin
            new_len = r_run_len + CW'(1);
            new_pix = r_run_pixel;
        end else begin
            new_len = CW'(1);
            new_pix = px;
            if (r_run_len == '0) begin
                o_cmd.x_kind = X_NONE;
            end else if (r_run_len >= CW'(3) ||
                         (r_run_len == CW'(2) && i_bpp >= 3'd2)) begin
                o_cmd.x_kind = X_REP;
            end else begin
                o_cmd.x_kind = X_APPEND;
            end
        end
        o_cmd.end_flag  = i_pix.line_end;
        o_cmd.end_len   = LEN_W'(new_len);
        o_cmd.end_pixel = new_pix;
        o_push = accept && (o_cmd.x_kind != X_NONE || i_pix.line_end);
        n_run_len   = r_run_len;
        n_run_pixel = r_run_pixel;
        if (accept) begin
            n_run_len   = i_pix.line_end ? '0 : new_len;
            n_run_pixel = new_pix;
        end
    end

    // Open run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_len   <= '0;
            r_run_pixel <= '0;
        end else begin
            r_run_len   <= n_run_len;
            r_run_pixel <= n_run_pixel;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tre_queue.sv
// ----------------------------------------------------------------------------
// tre_queue
// Two-entry command queue between the run detector and the chunk writer.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  tre_pkg::t_cmd       i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output tre_pkg::t_cmd       o_cmd
);
    import tre_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    // Storage, written at the write pointer.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(do_pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tre_back.sv
// ----------------------------------------------------------------------------
// tre_back
// Chunk writer: keeps the pending raw pixels, drains raw chunks up to four
// pixels a beat and emits repetition chunks into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_back #(
    parameter int CHUNK_MAX = 128
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  tre_pkg::t_cmd       i_q_cmd,
    output logic                o_q_pop,
    tre_out_if.source           o_rle
);
    import tre_pkg::*;

    localparam int CW   = $clog2(CHUNK_MAX + 1);
    localparam int ROWS = (CHUNK_MAX + LANES - 1) / LANES;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_APP   = 7'b0000010,
        S_FLUSH = 7'b0000100,
        S_RD    = 7'b0001000,
        S_LD    = 7'b0010000,
        S_REP   = 7'b0100000,
        S_END   = 7'b1000000
    } t_state;

    t_state           r_state;
    t_cmd             r_cmd;
    logic             r_stage;
    logic [1:0]       r_left;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_pos;
    logic             r_drain_app;
    logic [PIX_W-1:0] r_mem [LANES][ROWS];
    logic [PIX_W-1:0] r_rd  [LANES];

    logic             r_ov;
    logic             r_hv;
    logic [7:0]       r_hb;
    logic [2:0]       r_pc;
    logic [PIX_W-1:0] r_lane [LANES];
    logic             r_ld;
    logic             r_sl;

    logic             slot_free;
    logic             load;
    logic             we;
    logic [CW:0]      rem;
    logic [2:0]       cnt;
    logic             chunk_last;
    logic [CW:0]      pos_next;

    assign slot_free = !r_ov || o_rle.ready;
    assign load      = slot_free && (r_state == S_LD || r_state == S_REP);
    assign we        = (r_state == S_APP);
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;

    // Lanes of the current raw item.
    assign rem        = {1'b0, r_n} - {1'b0, r_pos};
    assign cnt        = (rem > (CW+1)'(LANES)) ? 3'(LANES) : 3'(rem);
    assign pos_next   = {1'b0, r_pos} + (CW+1)'(LANES);
    assign chunk_last = (pos_next >= {1'b0, r_n});

    // Raw pixel store, one memory per lane, read a row at a time.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (we && r_cnt[1:0] == 2'(l)) begin
                r_mem[l][RW'(r_cnt >> 2)] <= r_cmd.x_pixel;
            end
            r_rd[l] <= r_mem[l][RW'(r_pos >> 2)];
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stage     <= 1'b0;
            r_left      <= 2'd0;
            r_cnt       <= '0;
            r_n         <= '0;
            r_pos       <= '0;
            r_drain_app <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_rle.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd   <= i_q_cmd;
                        r_stage <= 1'b0;
                        r_left  <= i_q_cmd.x_len[1:0];
                        case (i_q_cmd.x_kind)
                            X_APPEND: r_state <= S_APP;
                            X_REP:    r_state <= S_FLUSH;
                            default:  r_state <= S_END;
                        endcase
                    end
                end
                S_APP: begin
                    r_left <= r_left - 2'd1;
                    if (r_cnt == CW'(CHUNK_MAX - 1)) begin
                        r_cnt       <= '0;
                        r_n         <= CW'(CHUNK_MAX);
                        r_pos       <= '0;
                        r_drain_app <= 1'b1;
                        r_state     <= S_RD;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                        if (r_left == 2'd1) begin
                            r_state <= S_END;
                        end
                    end
                end
                S_FLUSH: begin
                    r_cnt <= '0;
                    if (r_cnt != '0) begin
                        r_n         <= r_cnt;
                        r_pos       <= '0;
                        r_drain_app <= 1'b0;
                        r_state     <= S_RD;
                    end else begin
                        r_state <= S_REP;
                    end
                end
                S_RD: begin
                    r_state <= S_LD;
                end
                S_LD: begin
                    if (slot_free) begin
                        r_hv <= (r_pos == '0);
                        r_hb <= (r_pos == '0) ? 8'(r_n - CW'(1)) : 8'd0;
                        r_pc <= cnt;
                        for (int l = 0; l < LANES; l++) begin
                            r_lane[l] <= (3'(l) < cnt) ? r_rd[l] : '0;
                        end
                        r_ld <= 1'b0;
                        r_sl <= chunk_last && r_drain_app && !r_cmd.end_flag;
                        if (chunk_last) begin
                            if (!r_drain_app) begin
                                r_state <= S_REP;
                            end else if (r_left != 2'd0) begin
                                r_state <= S_APP;
                            end else begin
                                r_state <= S_END;
                            end
                        end else begin
                            r_pos   <= CW'(pos_next);
                            r_state <= S_RD;
                        end
                    end
                end
                S_REP: begin
                    if (slot_free) begin
                        r_hv <= 1'b1;
                        r_hb <= REP_BASE + (r_stage ? r_cmd.end_len : r_cmd.x_len);
                        r_pc <= 3'd1;
                        r_lane[0] <= r_stage ? r_cmd.end_pixel : r_cmd.x_pixel;
                        for (int l = 1; l < LANES; l++) begin
                            r_lane[l] <= '0;
                        end
                        r_ld    <= r_stage;
                        r_sl    <= r_stage || !r_cmd.end_flag;
                        r_state <= r_stage ? S_IDLE : S_END;
                    end
                end
                S_END: begin
                    if (!r_stage && r_cmd.end_flag) begin
                        r_stage <= 1'b1;
                        r_state <= S_FLUSH;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output beat.
    assign o_rle.valid        = r_ov;
    assign o_rle.header_valid = r_hv;
    assign o_rle.header_byte  = r_hb;
    assign o_rle.pixel_count  = r_pc;
    assign o_rle.pixel_a      = r_lane[0];
    assign o_rle.pixel_b      = r_lane[1];
    assign o_rle.pixel_c      = r_lane[2];
    assign o_rle.pixel_d      = r_lane[3];
    assign o_rle.line_done    = r_ld;
    assign o_rle.step_last    = r_sl;

endmodule

`default_nettype wire

FILE: rtl/core/tga_rle_line_encoder_top.sv
// ----------------------------------------------------------------------------
// tga_rle_line_encoder_top
// TGA run-length encoder for image lines.
// ----------------------------------------------------------------------------
// Pixels enter on i_pix, one per beat, with line_end on the last pixel of a
// line. Encoded beats leave on o_rle: a beat holds an optional chunk header
// and up to four pixels, with line_done on the final beat of a line and
// step_last on the last beat caused by one input pixel.
// The run detector takes one pixel per cycle while its two-entry command
// queue has room. The chunk writer picks up a command, appends raw pixels
// one at a time, steps between chunks, reads memory and then loads the
// output register for each raw beat, and loads each repetition beat; a
// load waits while the output register holds an untaken beat. A pixel that
// only extends a run issues no command, so the detector can take further
// pixels while the writer is still busy with earlier commands.
// bytes_per_pixel is written through the APB port at address 0. The user
// must write it only while the block is idle; the block itself does not
// enforce this. Reset clears the run, the raw count and the queue.
// When o_rle stalls, the output register holds its beat, the chunk writer
// waits, the queue fills and then i_pix.ready drops.
`default_nettype none

module tga_rle_line_encoder_top #(
    parameter int CHUNK_MAX = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    tre_in_if.sink           i_pix,
    tre_out_if.source        o_rle
);
    import tre_pkg::*;

    logic [2:0] r_bpp;
    logic [2:0] eff_bpp;
    logic       q_push, q_full, q_valid, q_pop;
    t_cmd       f_cmd, q_cmd;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp <= BPP_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_BPP) begin
            r_bpp <= pwdata[2:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BPP) ? {29'd0, r_bpp} : 32'd0;

    // Out-of-range widths saturate.
    always_comb begin
        if (r_bpp == 3'd0) begin
            eff_bpp = 3'd1;
        end else if (r_bpp > 3'd4) begin
            eff_bpp = 3'd4;
        end else begin
            eff_bpp = r_bpp;
        end
    end

    tre_front #(.CHUNK_MAX(CHUNK_MAX)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bpp    (eff_bpp),
        .i_pix    (i_pix),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (f_cmd)
    );

    tre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tre_back #(.CHUNK_MAX(CHUNK_MAX)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_rle     (o_rle)
    );

endmodule

`default_nettype wire

FILE: test/tga_rle_line_encoder_checker.sv
// ----------------------------------------------------------------------------
// tga_rle_line_encoder_checker
// Watches the pixel, encoded and APB channels of the TGA run-length encoder.
// It predicts each encoded beat from the accepted pixels and the current
// bytes_per_pixel setting. It then compares every beat field by field and
// counts the mismatching beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_line_encoder_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    tre_in_if                i_pix,
    tre_out_if               i_rle,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_beat_count
);
    import tre_pkg::*;

    localparam int CHUNK = 128;

    typedef struct packed {
        logic        hv;
        logic [7:0]  hb;
        logic [2:0]  cnt;
        logic [31:0] pa;
        logic [31:0] pb;
        logic [31:0] pc;
        logic [31:0] pd;
        logic        ld;
        logic        sl;
    } t_rle_beat;

    // Encoder state as the predictor sees it.
    logic [31:0] pend_raw[CHUNK];
    int          pend_n;
    logic [31:0] run_px;
    int          run_len;
    logic [2:0]  bpp_reg;
    int          beats_this_pixel;
    t_rle_beat   beat_q[$];

    function automatic int clamp_bpp(logic [2:0] v);
        if (v == 3'd0) return 1;
        if (v > 3'd4) return 4;
        return int'(v);
    endfunction

    task automatic push_beat(logic hv, logic [7:0] hb, int cnt, logic [31:0] l0,
                             logic [31:0] l1, logic [31:0] l2, logic [31:0] l3);
        t_rle_beat b;
        b = '0;
        b.hv = hv;
        b.hb = hv ? hb : 8'd0;
        b.cnt = cnt[2:0];
        b.pa = l0;
        b.pb = (cnt > 1) ? l1 : 32'd0;
        b.pc = (cnt > 2) ? l2 : 32'd0;
        b.pd = (cnt > 3) ? l3 : 32'd0;
        beat_q.push_back(b);
        beats_this_pixel++;
    endtask

    // A raw chunk leaves as beats of up to four pixels, header on the first.
    task automatic emit_raw_chunk(int n);
        int pos;
        int cnt;
        pos = 0;
        while (pos < n) begin
            cnt = (n - pos > 4) ? 4 : n - pos;
            push_beat(pos == 0, 8'(n - 1), cnt, pend_raw[pos],
                      (pos + 1 < CHUNK) ? pend_raw[pos + 1] : 32'd0,
                      (pos + 2 < CHUNK) ? pend_raw[pos + 2] : 32'd0,
                      (pos + 3 < CHUNK) ? pend_raw[pos + 3] : 32'd0);
            pos += cnt;
        end
    endtask

    // Close the open run: a repetition chunk if it pays off or ends the line,
    // otherwise its pixels join the pending raw pixels.
    task automatic close_run(bit at_end);
        if (run_len == 0) return;
        if ((run_len - 1) * clamp_bpp(bpp_reg) >= 2 || at_end) begin
            if (pend_n > 0) emit_raw_chunk(pend_n);
            pend_n = 0;
            push_beat(1'b1, REP_BASE + 8'(run_len), 1, run_px, 32'd0, 32'd0, 32'd0);
        end else begin
            for (int i = 0; i < run_len; i++) begin
                pend_raw[pend_n] = run_px;
                pend_n++;
                if (pend_n == CHUNK) begin
                    emit_raw_chunk(CHUNK);
                    pend_n = 0;
                end
            end
        end
        run_len = 0;
    endtask

    task automatic encode_pixel(logic [31:0] raw_px, logic le);
        logic [31:0] px;
        px = raw_px & (32'hffff_ffff >> (8 * (4 - clamp_bpp(bpp_reg))));
        beats_this_pixel = 0;
        if (run_len > 0 && px == run_px && run_len < CHUNK) begin
            run_len++;
        end else begin
            close_run(1'b0);
            run_px = px;
            run_len = 1;
        end
        if (le) begin
            close_run(1'b1);
            pend_n = 0;
            if (beats_this_pixel > 0) beat_q[beat_q.size() - 1].ld = 1'b1;
        end
        if (beats_this_pixel > 0) beat_q[beat_q.size() - 1].sl = 1'b1;
    endtask

    task automatic report(string what, t_rle_beat exp_b, t_rle_beat got_b);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("MISMATCH %s at beat %0d: expected %p, got %p", what,
                     o_beat_count, exp_b, got_b);
        end
    endtask

    assign o_pending = beat_q.size();

    always @(posedge i_clk) begin
        t_rle_beat got;
        t_rle_beat exp_b;
        if (!i_rst_n) begin
            pend_n = 0;
            run_px = '0;
            run_len = 0;
            bpp_reg = BPP_RESET;
            o_fail_count = 0;
            o_beat_count = 0;
            beat_q.delete();
        end else begin
            // Register writes at address 0 are booked; the bench itself must make them only while the block is idle.
            if (psel && penable && pwrite && pready && paddr == 3'd0) begin
                bpp_reg = pwdata[2:0];
            end
            if (i_pix.valid && i_pix.ready) begin
                encode_pixel(i_pix.pixel_value, i_pix.line_end);
            end
            if (i_rle.valid && i_rle.ready) begin
                got.hv = i_rle.header_valid;
                got.hb = i_rle.header_byte;
                got.cnt = i_rle.pixel_count;
                got.pa = i_rle.pixel_a;
                got.pb = i_rle.pixel_b;
                got.pc = i_rle.pixel_c;
                got.pd = i_rle.pixel_d;
                got.ld = i_rle.line_done;
                got.sl = i_rle.step_last;
                if (beat_q.size() == 0) begin
                    report("unexpected beat", '0, got);
                end else begin
                    exp_b = beat_q.pop_front();
                    if (got.hv !== exp_b.hv) report("header_valid", exp_b, got);
                    else if (got.hb !== exp_b.hb) report("header_byte", exp_b, got);
                    else if (got.cnt !== exp_b.cnt) report("pixel_count", exp_b, got);
                    else if (got.pa !== exp_b.pa) report("pixel_a", exp_b, got);
                    else if (got.pb !== exp_b.pb) report("pixel_b", exp_b, got);
                    else if (got.pc !== exp_b.pc) report("pixel_c", exp_b, got);
                    else if (got.pd !== exp_b.pd) report("pixel_d", exp_b, got);
                    else if (got.ld !== exp_b.ld) report("line_done", exp_b, got);
                    else if (got.sl !== exp_b.sl) report("step_last", exp_b, got);
                end
                o_beat_count++;
            end
        end
    end

endmodule

`default_nettype wire

FILE: test/tga_rle_line_encoder_top_test.sv
// ----------------------------------------------------------------------------
// tga_rle_line_encoder_top_test
// Drives pixel lines and bytes_per_pixel settings into the TGA RLE encoder.
// Directed lines come first, then random lines of runs and scattered pixels
// under every setting, with random stalls on both channels but for the last
// two phases. The checker beside the block predicts and compares the beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_line_encoder_top_test;
    import tre_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 120;
    localparam logic [2:0] ADDR_BPP = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          beat_count;
    int          cycles = 0;
    int          snd_idle = 9;
    int          rcv_idle = 73;
    int          pixels_sent = 0;
    int          lines_sent = 0;

    tre_in_if  pix_ch ();
    tre_out_if rle_ch ();

    tga_rle_line_encoder_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_ch),
        .o_rle   (rle_ch)
    );

    tga_rle_line_encoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .i_pix        (pix_ch),
        .i_rle        (rle_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_beat_count (beat_count)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        pix_ch.valid = 1'b0;
        pix_ch.pixel_value = '0;
        pix_ch.line_end = 1'b0;
        rle_ch.ready = 1'b0;
    end

    // Receiver stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        rle_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_pixel(logic [31:0] px, logic le);
        while ($urandom_range(0, 99) < snd_idle) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_value <= px;
        pix_ch.line_end <= le;
        forever begin
            @(negedge i_clk);
            if (pix_ch.ready) break;
        end
        @(posedge i_clk);
        pixels_sent++;
        if (le) lines_sent++;
    endtask

    // Hold the input until every expected beat is out and the writer is idle.
    // The first edge lets the checker book the last accepted pixel.
    task automatic drain();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // A random line: runs of mixed length drawn from a small palette whose
    // upper bytes sometimes vary, so masked comparison matters.
    task automatic send_random_line();
        logic [31:0] pal[4];
        logic [31:0] px;
        int segs;
        int len;
        int pick;
        foreach (pal[k]) pal[k] = $urandom();
        segs = $urandom_range(1, 3);
        for (int s = 0; s < segs; s++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) len = 1;
            else if (pick < 82) len = $urandom_range(2, 3);
            else len = $urandom_range(4, 6);
            px = ($urandom_range(0, 3) == 0) ? $urandom() : pal[$urandom_range(0, 3)];
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 3) == 0) px[31:8] = 24'($urandom());
                send_pixel(px, (s == segs - 1) && (i == len - 1));
            end
        end
    endtask

    logic [2:0] bpp_plan[8] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd5, 3'd7, 3'd6, 3'd4};

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines at the reset setting of four bytes per pixel.
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'hffff_ffff, 1'b1);
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'h1234_5678, 1'b1);
        send_pixel(32'haaaa_5555, 1'b0);
        send_pixel(32'h5555_aaaa, 1'b0);
        send_pixel(32'h5555_aaaa, 1'b0);
        send_pixel(32'h5555_aaaa, 1'b0);
        send_pixel(32'h0000_0001, 1'b0);
        send_pixel(32'h8000_0000, 1'b0);
        send_pixel(32'hffff_ffff, 1'b1);
        send_pixel(32'h0100_00ff, 1'b0);
        send_pixel(32'h0200_00ff, 1'b0);
        send_pixel(32'h0300_00ff, 1'b1);
        drain();
        apb_write(ADDR_UNUSED, 32'h0000_0001);
        apb_write(ADDR_BPP, 32'hffff_fff9);
        // Masked pixels that differ only in high bytes merge at one byte.
        send_pixel(32'h0100_00ff, 1'b0);
        send_pixel(32'h0200_00ff, 1'b0);
        send_pixel(32'h0300_00ff, 1'b0);
        send_pixel(32'h0000_0011, 1'b0);
        send_pixel(32'h0000_0011, 1'b0);
        send_pixel(32'h0000_0022, 1'b1);

        // A full raw chunk is sent early: one single pixel, then pairs that
        // stay raw at one byte, so the chunk fills in the middle of a pair.
        send_pixel(32'h0000_0000, 1'b0);
        for (int i = 1; i <= 64; i++) begin
            send_pixel(32'(i * 37), 1'b0);
            send_pixel(32'(i * 37) | 32'h5500_0000, 1'b0);
        end
        send_pixel(32'(65 * 37), 1'b1);

        // Random phases under each setting; the idling pattern moves on.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                snd_idle = 73;
                rcv_idle = 9;
            end else if (ph == 6) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            drain();
            apb_write(ADDR_BPP, {$urandom() & 32'hffff_fff8} | 32'(bpp_plan[ph]));
            send_random_line();
        end
        drain();

        $display("Sent %0d pixels in %0d lines under all bytes_per_pixel settings,",
                 pixels_sent, lines_sent);
        $display("and checked %0d encoded beats with stalls on both sides.", beat_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
